>>> hdl/tcpr_pkg.sv
package tcpr_pkg;

  localparam int IDX_W  = 16;
  localparam int WIN_W  = 7;
  localparam int MS_W   = 16;
  localparam int FX_W   = 19;
  localparam int ALU_W  = 23;
  localparam int CFG_IDX_W = 2;

  localparam logic [WIN_W-1:0] MAX_WINDOW   = 7'd64;
  localparam logic [WIN_W-1:0] MIN_SSTHRESH = 7'd2;

  localparam logic [IDX_W-1:0] RST_TOTAL    = 16'd1;
  localparam logic [WIN_W-1:0] RST_SSTHRESH = 7'd64;
  localparam logic [MS_W-1:0]  RST_TIMEOUT  = 16'd1200;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SSTHRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  typedef enum logic [2:0] {
    W_IDLE,
    W_EVAL,
    W_DECIDE,
    W_RTT_WAIT,
    W_EMIT,
    W_STATUS
  } win_state_e;

  typedef enum logic [2:0] {
    R_IDLE,
    R_EST_MUL,
    R_EST_ADD,
    R_DIFF,
    R_ABS,
    R_DEV_MUL,
    R_DEV_ADD,
    R_TIMEOUT
  } rtt_state_e;

  typedef struct packed {
    logic start;
    logic load;
  } rtt_req_t;

  typedef struct packed {
    logic             send_valid;
    logic [IDX_W-1:0] send_index;
    logic             is_resend;
    logic             finish;
    logic [WIN_W-1:0] window_now;
    logic [WIN_W-1:0] threshold_now;
    logic [MS_W-1:0]  timeout_now_ms;
    logic             last;
  } result_t;

endpackage

>>> hdl/tcpr_rtt.sv
module tcpr_rtt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tcpr_pkg::rtt_req_t       req_i,
  input  logic [tcpr_pkg::MS_W-1:0] sample_ms_i,
  input  logic [tcpr_pkg::MS_W-1:0] init_ms_i,
  output logic                     busy_o,
  output logic [tcpr_pkg::MS_W-1:0] timeout_ms_o
);
  import tcpr_pkg::*;

  rtt_state_e        state_q, state_d;
  logic [FX_W-1:0]   est_q, est_d;
  logic [FX_W-1:0]   dev_q, dev_d;
  logic [FX_W-1:0]   s8_q, s8_d;
  logic [FX_W-1:0]   diff_q, diff_d;
  logic [ALU_W-1:0]  acc_q, acc_d;
  logic [MS_W-1:0]   timeout_q, timeout_d;

  logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic [ALU_W-4:0]  tmo_full;

  // The one adder in this unit; every step of the estimator goes through it.
  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};
  assign tmo_full = alu_sum[ALU_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= R_IDLE;
      est_q     <= {RST_TIMEOUT, 3'b000};
      dev_q     <= '0;
      timeout_q <= RST_TIMEOUT;
    end else begin
      state_q   <= state_d;
      est_q     <= est_d;
      dev_q     <= dev_d;
      timeout_q <= timeout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_q   <= s8_d;
    diff_q <= diff_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    state_d   = state_q;
    est_d     = est_q;
    dev_d     = dev_q;
    s8_d      = s8_q;
    diff_d    = diff_q;
    acc_d     = acc_q;
    timeout_d = timeout_q;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          if (req_i.load) begin
            est_d   = {init_ms_i, 3'b000};
            dev_d   = '0;
            state_d = R_TIMEOUT;
          end else begin
            s8_d    = {sample_ms_i, 3'b000};
            state_d = R_EST_MUL;
          end
        end
      end
      R_EST_MUL: begin
        alu_a   = {1'b0, est_q, 3'b000};
        alu_b   = {4'b0000, est_q};
        alu_sub = 1'b1;
        acc_d   = alu_sum;
        state_d = R_EST_ADD;
      end
      R_EST_ADD: begin
        alu_a   = acc_q;
        alu_b   = {4'b0000, s8_q};
        est_d   = alu_sum[FX_W+2:3];
        state_d = R_DIFF;
      end
      R_DIFF: begin
        alu_a   = {4'b0000, s8_q};
        alu_b   = {4'b0000, est_q};
        alu_sub = 1'b1;
        acc_d   = alu_sum;
        state_d = R_ABS;
      end
      R_ABS: begin
        if (acc_q[ALU_W-1]) begin
          alu_b   = acc_q;
          alu_sub = 1'b1;
        end else begin
          alu_a = acc_q;
        end
        diff_d  = alu_sum[FX_W-1:0];
        state_d = R_DEV_MUL;
      end
      R_DEV_MUL: begin
        alu_a   = {3'b000, dev_q, 1'b0};
        alu_b   = {4'b0000, dev_q};
        acc_d   = alu_sum;
        state_d = R_DEV_ADD;
      end
      R_DEV_ADD: begin
        alu_a   = acc_q;
        alu_b   = {4'b0000, diff_q};
        dev_d   = alu_sum[FX_W+1:2];
        state_d = R_TIMEOUT;
      end
      R_TIMEOUT: begin
        alu_a = {4'b0000, est_q};
        alu_b = {2'b00, dev_q, 2'b00};
        if (tmo_full > {{(ALU_W-3-MS_W){1'b0}}, {MS_W{1'b1}}}) begin
          timeout_d = {MS_W{1'b1}};
        end else if (tmo_full == '0) begin
          timeout_d = {{(MS_W-1){1'b0}}, 1'b1};
        end else begin
          timeout_d = tmo_full[MS_W-1:0];
        end
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != R_IDLE);
  assign timeout_ms_o = timeout_q;

  a_timeout_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timeout_q != '0)
    else $error("Retransmit timeout reached zero.");

  a_load_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == R_IDLE && req_i.start && req_i.load) |=> state_q == R_TIMEOUT)
    else $error("A load did not go straight to the timeout step.");

endmodule

>>> hdl/tcpr_win.sv
module tcpr_win (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_fire_i,
  input  logic [1:0]                 operation_i,
  input  logic [tcpr_pkg::IDX_W-1:0] ack_i,
  input  logic [tcpr_pkg::MS_W-1:0]  sample_i,
  input  logic [tcpr_pkg::IDX_W-1:0] total_i,
  input  logic [tcpr_pkg::WIN_W-1:0] init_ssth_i,
  output logic                       idle_o,
  output tcpr_pkg::rtt_req_t         rtt_req_o,
  output logic [tcpr_pkg::MS_W-1:0]  rtt_sample_o,
  input  logic                       rtt_busy_i,
  input  logic [tcpr_pkg::MS_W-1:0]  timeout_ms_i,
  output logic                       push_o,
  output tcpr_pkg::result_t          res_o,
  input  logic                       push_ready_i
);
  import tcpr_pkg::*;

  win_state_e         state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic [IDX_W-1:0]   ack_q, ack_d;
  logic [MS_W-1:0]    sample_q, sample_d;
  logic [WIN_W-1:0]   cwnd_q, cwnd_d;
  logic [WIN_W-1:0]   ssth_q, ssth_d;
  logic [WIN_W-1:0]   avoid_q, avoid_d;
  logic [IDX_W-1:0]   highest_q, highest_d;
  logic [1:0]         dup_q, dup_d;
  logic [IDX_W-1:0]   frx_q, frx_d;
  logic [IDX_W-1:0]   base_q, base_d;
  logic [IDX_W-1:0]   nu_q, nu_d;
  logic [IDX_W:0]     hi_q, hi_d;
  logic               end_q, end_d;
  logic               resent_q, resent_d;
  logic               done_q, done_d;
  logic               fin_q, fin_d;
  logic               mode_q, mode_d;

  logic [IDX_W-1:0]   ack_sat;
  logic [1:0]         dup_inc;
  logic [WIN_W-1:0]   avoid_inc;
  logic [WIN_W-1:0]   half;
  logic [WIN_W-1:0]   th_clamp;
  logic [IDX_W:0]     hi_c;
  logic [IDX_W:0]     nu_ext;
  logic [IDX_W:0]     nu1;
  logic               more;
  logic               do_shrink;

  assign ack_sat   = (ack_q > total_i) ? total_i : ack_q;
  assign dup_inc   = (dup_q == 2'd3) ? 2'd3 : dup_q + 2'd1;
  assign avoid_inc = avoid_q + 7'd1;
  assign half      = {1'b0, cwnd_q[WIN_W-1:1]};
  assign th_clamp  = (init_ssth_i < MIN_SSTHRESH) ? MIN_SSTHRESH :
                     (init_ssth_i > MAX_WINDOW) ? MAX_WINDOW : init_ssth_i;
  assign hi_c      = {1'b0, base_q} + {{(IDX_W+1-WIN_W){1'b0}}, cwnd_q};
  assign nu_ext    = {1'b0, nu_q};
  assign nu1       = nu_ext + {{IDX_W{1'b0}}, 1'b1};
  assign more      = (nu1 < hi_q) && (nu1 < {1'b0, total_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      cwnd_q    <= 7'd1;
      ssth_q    <= RST_SSTHRESH;
      avoid_q   <= '0;
      highest_q <= '0;
      dup_q     <= '0;
      frx_q     <= '0;
      base_q    <= '0;
      nu_q      <= '0;
      hi_q      <= '0;
      end_q     <= 1'b0;
      resent_q  <= 1'b0;
      done_q    <= 1'b0;
      fin_q     <= 1'b0;
      mode_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cwnd_q    <= cwnd_d;
      ssth_q    <= ssth_d;
      avoid_q   <= avoid_d;
      highest_q <= highest_d;
      dup_q     <= dup_d;
      frx_q     <= frx_d;
      base_q    <= base_d;
      nu_q      <= nu_d;
      hi_q      <= hi_d;
      end_q     <= end_d;
      resent_q  <= resent_d;
      done_q    <= done_d;
      fin_q     <= fin_d;
      mode_q    <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ack_q    <= ack_d;
    sample_q <= sample_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    ack_d     = ack_q;
    sample_d  = sample_q;
    cwnd_d    = cwnd_q;
    ssth_d    = ssth_q;
    avoid_d   = avoid_q;
    highest_d = highest_q;
    dup_d     = dup_q;
    frx_d     = frx_q;
    base_d    = base_q;
    nu_d      = nu_q;
    hi_d      = hi_q;
    end_d     = end_q;
    resent_d  = resent_q;
    done_d    = done_q;
    fin_d     = fin_q;
    mode_d    = mode_q;
    do_shrink = 1'b0;
    idle_o    = 1'b0;
    push_o    = 1'b0;
    rtt_req_o = '0;
    res_o.send_valid     = 1'b0;
    res_o.send_index     = '0;
    res_o.is_resend      = 1'b0;
    res_o.finish         = fin_q;
    res_o.window_now     = cwnd_q;
    res_o.threshold_now  = ssth_q;
    res_o.timeout_now_ms = timeout_ms_i;
    res_o.last           = 1'b1;
    case (state_q)
      W_IDLE: begin
        idle_o = 1'b1;
        if (in_fire_i) begin
          op_d     = operation_i;
          ack_d    = ack_i;
          sample_d = sample_i;
          state_d  = W_EVAL;
        end
      end
      W_EVAL: begin
        fin_d   = 1'b0;
        state_d = W_STATUS;
        case (op_q)
          OP_START: begin
            cwnd_d    = 7'd1;
            ssth_d    = th_clamp;
            avoid_d   = '0;
            highest_d = '0;
            dup_d     = '0;
            frx_d     = '0;
            base_d    = '0;
            nu_d      = '0;
            hi_d      = {{IDX_W{1'b0}}, 1'b1};
            end_d     = 1'b0;
            resent_d  = 1'b0;
            done_d    = 1'b0;
            mode_d    = 1'b0;
            rtt_req_o.start = 1'b1;
            rtt_req_o.load  = 1'b1;
            state_d   = W_RTT_WAIT;
          end
          OP_ACK: begin
            if (!done_q) begin
              if (ack_sat == highest_q && highest_q != total_i) begin
                dup_d = dup_inc;
                if (dup_inc == 2'd3 && highest_q != frx_q) begin
                  dup_d     = '0;
                  frx_d     = highest_q;
                  do_shrink = 1'b1;
                end
              end else begin
                if (cwnd_q > ssth_q) begin
                  avoid_d = avoid_inc;
                  if (avoid_inc >= cwnd_q) begin
                    if (cwnd_q < MAX_WINDOW) begin
                      cwnd_d = cwnd_q + 7'd1;
                    end
                    avoid_d = '0;
                  end
                end else if (cwnd_q < MAX_WINDOW) begin
                  cwnd_d = cwnd_q + 7'd1;
                end
                if (end_q && ack_sat == total_i) begin
                  done_d = 1'b1;
                  fin_d  = 1'b1;
                end else if (ack_sat >= highest_q) begin
                  dup_d     = '0;
                  highest_d = ack_sat;
                  base_d    = ack_sat;
                  if (nu_q < ack_sat) begin
                    nu_d = ack_sat;
                  end
                  state_d = W_DECIDE;
                end
              end
            end
          end
          OP_TIMEOUT: begin
            if (!done_q) begin
              do_shrink = 1'b1;
            end
          end
          default: begin
            state_d = W_STATUS;
          end
        endcase
        if (do_shrink) begin
          ssth_d  = (half > MIN_SSTHRESH) ? half : MIN_SSTHRESH;
          avoid_d = '0;
          cwnd_d  = 7'd1;
          if (base_q < total_i) begin
            nu_d     = base_q;
            hi_d     = {1'b0, base_q} + {{IDX_W{1'b0}}, 1'b1};
            mode_d   = 1'b1;
            resent_d = 1'b1;
            state_d  = W_EMIT;
          end
        end
      end
      W_DECIDE: begin
        hi_d   = hi_c;
        mode_d = 1'b0;
        if (nu_ext < hi_c) begin
          if (nu_q < total_i) begin
            if (!resent_q) begin
              rtt_req_o.start = 1'b1;
              state_d         = W_RTT_WAIT;
            end else begin
              state_d = W_EMIT;
            end
          end else begin
            end_d   = 1'b1;
            state_d = W_STATUS;
          end
        end else begin
          state_d = W_STATUS;
        end
      end
      W_RTT_WAIT: begin
        if (!rtt_busy_i) begin
          if (nu_ext < hi_q && nu_q < total_i) begin
            state_d = W_EMIT;
          end else begin
            state_d = W_STATUS;
          end
        end
      end
      W_EMIT: begin
        push_o           = 1'b1;
        res_o.send_valid = 1'b1;
        res_o.send_index = nu_q;
        res_o.is_resend  = mode_q;
        res_o.last       = !more;
        if (push_ready_i) begin
          nu_d     = nu1[IDX_W-1:0];
          resent_d = mode_q;
          if (nu1 < hi_q && nu1 >= {1'b0, total_i}) begin
            end_d = 1'b1;
          end
          if (!more) begin
            state_d = W_IDLE;
          end
        end
      end
      W_STATUS: begin
        push_o = 1'b1;
        if (push_ready_i) begin
          state_d = W_IDLE;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  assign rtt_sample_o = sample_q;

  a_cwnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cwnd_q != '0 && cwnd_q <= MAX_WINDOW)
    else $error("Congestion window out of range.");

  a_rtt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rtt_req_o.start |-> !rtt_busy_i)
    else $error("Estimator started while still busy.");

  a_send_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.send_valid) |-> ({1'b0, res_o.send_index} < hi_q))
    else $error("Send index beyond the window.");

endmodule

>>> hdl/tcp_reno_congestion_window.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_stall_o   | operation, ack_packets, rtt_sample_ms
// out      | output    | out_valid_o / out_stall_i | send and status fields, last
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The sequencer captures an event while idle and evaluates it, then emits one
// result item per cycle while the output is not stalled. An ack that sends new
// data first runs the RTT estimator, seven steps on its single adder, unless the
// last send was a retransmission; a start event runs its one-step timeout reload.
// The wait for the estimator ends in the cycle after its last step.
// Reset clears all control state and loads the register reset values.
// A stalled output holds the result register; the sequencer waits on it.
module tcp_reno_congestion_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [tcpr_pkg::IDX_W-1:0]     ack_packets_i,
  input  logic [tcpr_pkg::MS_W-1:0]      rtt_sample_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           send_valid_o,
  output logic [tcpr_pkg::IDX_W-1:0]     send_index_o,
  output logic                           is_resend_o,
  output logic                           finish_o,
  output logic [tcpr_pkg::WIN_W-1:0]     window_now_o,
  output logic [tcpr_pkg::WIN_W-1:0]     threshold_now_o,
  output logic [tcpr_pkg::MS_W-1:0]      timeout_now_ms_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcpr_pkg::MS_W-1:0]      cfg_data_i
);
  import tcpr_pkg::*;

  logic [IDX_W-1:0]  total_q;
  logic [WIN_W-1:0]  init_ssth_q;
  logic [MS_W-1:0]   init_to_q;

  logic              idle;
  logic              in_fire;
  logic              cfg_fire;
  rtt_req_t          rtt_req;
  logic [MS_W-1:0]   rtt_sample;
  logic              rtt_busy;
  logic [MS_W-1:0]   timeout_ms;
  logic              push;
  logic              push_ready;
  result_t           res;
  result_t           out_q;
  logic              out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = !idle;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign push_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= RST_TOTAL;
      init_ssth_q <= RST_SSTHRESH;
      init_to_q   <= RST_TIMEOUT;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CFG_TOTAL:    total_q     <= cfg_data_i;
        CFG_SSTHRESH: init_ssth_q <= cfg_data_i[WIN_W-1:0];
        CFG_TIMEOUT:  init_to_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tcpr_win u_win (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .operation_i  (operation_i),
    .ack_i        (ack_packets_i),
    .sample_i     (rtt_sample_ms_i),
    .total_i      (total_q),
    .init_ssth_i  (init_ssth_q),
    .idle_o       (idle),
    .rtt_req_o    (rtt_req),
    .rtt_sample_o (rtt_sample),
    .rtt_busy_i   (rtt_busy),
    .timeout_ms_i (timeout_ms),
    .push_o       (push),
    .res_o        (res),
    .push_ready_i (push_ready)
  );

  tcpr_rtt u_rtt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (rtt_req),
    .sample_ms_i  (rtt_sample),
    .init_ms_i    (init_to_q),
    .busy_o       (rtt_busy),
    .timeout_ms_o (timeout_ms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push && push_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && push_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign send_valid_o     = out_q.send_valid;
  assign send_index_o     = out_q.send_index;
  assign is_resend_o      = out_q.is_resend;
  assign finish_o         = out_q.finish;
  assign window_now_o     = out_q.window_now;
  assign threshold_now_o  = out_q.threshold_now;
  assign timeout_now_ms_o = out_q.timeout_now_ms;
  assign last_o           = out_q.last;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tcpr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  class congestion_scoreboard;
    logic [15:0] total_reg;
    logic [6:0]  ssthresh_reg;
    logic [15:0] timeout_reg;
    logic [6:0]  cwnd;
    logic [6:0]  ssthresh;
    logic [6:0]  avoid_count;
    logic [15:0] highest_ack;
    logic [15:0] fast_retx_ack;
    logic [15:0] window_base;
    logic [15:0] next_unsent;
    logic [1:0]  dup_count;
    logic        end_reached;
    logic        resent;
    logic        done;
    logic [18:0] est_fx;
    logic [18:0] dev_fx;
    logic [15:0] sent_index[$];
    logic        sent_resend[$];
    result_t     expected_sends[$];
    int          errors;

    function new();
      total_reg = RST_TOTAL;
      ssthresh_reg = RST_SSTHRESH;
      timeout_reg = RST_TIMEOUT;
      errors = 0;
      restart_transfer();
    endfunction

    function void restart_transfer();
      cwnd = 7'd1;
      if (ssthresh_reg < MIN_SSTHRESH) ssthresh = MIN_SSTHRESH;
      else if (ssthresh_reg > MAX_WINDOW) ssthresh = MAX_WINDOW;
      else ssthresh = ssthresh_reg;
      avoid_count = '0;
      highest_ack = '0;
      dup_count = '0;
      fast_retx_ack = '0;
      window_base = '0;
      next_unsent = '0;
      end_reached = 1'b0;
      resent = 1'b0;
      done = 1'b0;
      est_fx = {timeout_reg, 3'b000};
      dev_fx = '0;
    endfunction

    function void note_register(logic [1:0] index, logic [15:0] data);
      case (index)
        CFG_TOTAL: total_reg = data;
        CFG_SSTHRESH: ssthresh_reg = data[6:0];
        CFG_TIMEOUT: timeout_reg = data;
        default: ;
      endcase
    endfunction

    function void shrink_and_resend();
      logic [6:0] half;
      half = cwnd >> 1;
      ssthresh = (half > MIN_SSTHRESH) ? half : MIN_SSTHRESH;
      avoid_count = '0;
      cwnd = 7'd1;
      if (window_base < total_reg) begin
        sent_index.push_back(window_base);
        sent_resend.push_back(1'b1);
        next_unsent = window_base + 16'd1;
        resent = 1'b1;
      end
    endfunction

    function void accept_event(logic [1:0] op, logic [15:0] ack, logic [15:0] sample);
      logic [15:0] a;
      logic [31:0] acc;
      logic [31:0] s8;
      logic [31:0] diff;
      logic [31:0] limit;
      logic [31:0] i;
      logic [31:0] t;
      logic        first;
      logic        fin;
      result_t     r;
      int          n;
      sent_index.delete();
      sent_resend.delete();
      fin = 1'b0;
      if (op == OP_START) begin
        restart_transfer();
        if (total_reg != 16'd0) begin
          sent_index.push_back(16'd0);
          sent_resend.push_back(1'b0);
          next_unsent = 16'd1;
        end
      end else if (op == OP_ACK && !done) begin
        a = (ack > total_reg) ? total_reg : ack;
        if (a == highest_ack && highest_ack != total_reg) begin
          if (dup_count != 2'd3) dup_count++;
          if (dup_count == 2'd3 && highest_ack != fast_retx_ack) begin
            dup_count = '0;
            fast_retx_ack = highest_ack;
            shrink_and_resend();
          end
        end else begin
          if (cwnd > ssthresh) begin
            avoid_count++;
            if (avoid_count >= cwnd) begin
              if (cwnd < MAX_WINDOW) cwnd++;
              avoid_count = '0;
            end
          end else if (cwnd < MAX_WINDOW) begin
            cwnd++;
          end
          if (end_reached && a == total_reg) begin
            done = 1'b1;
            fin = 1'b1;
          end else if (a >= highest_ack) begin
            limit = 32'(a) + 32'(cwnd);
            first = 1'b1;
            dup_count = '0;
            highest_ack = a;
            window_base = a;
            if (next_unsent < a) next_unsent = a;
            for (i = 32'(next_unsent); i < limit && sent_index.size() < int'(MAX_WINDOW);
                 i++) begin
              if (i >= 32'(total_reg)) begin
                end_reached = 1'b1;
                break;
              end
              // Karn's rule: no RTT sample right after a retransmission.
              if (first && !resent) begin
                s8 = {13'd0, sample, 3'b000};
                acc = 32'd7 * 32'(est_fx) + s8;
                est_fx = acc[21:3];
                diff = (s8 > 32'(est_fx)) ? s8 - 32'(est_fx) : 32'(est_fx) - s8;
                acc = 32'd3 * 32'(dev_fx) + diff;
                dev_fx = acc[20:2];
              end
              first = 1'b0;
              sent_index.push_back(i[15:0]);
              sent_resend.push_back(1'b0);
              next_unsent = i[15:0] + 16'd1;
              resent = 1'b0;
            end
          end
        end
      end else if (op == OP_TIMEOUT && !done) begin
        shrink_and_resend();
      end

      acc = 32'(est_fx) + 32'd4 * 32'(dev_fx);
      t = acc >> 3;
      if (t > 32'd65535) t = 32'd65535;
      if (t < 32'd1) t = 32'd1;
      n = (sent_index.size() > 0) ? sent_index.size() : 1;
      for (int k = 0; k < n; k++) begin
        r.send_valid = sent_index.size() > 0;
        r.send_index = r.send_valid ? sent_index[k] : '0;
        r.is_resend = r.send_valid ? sent_resend[k] : 1'b0;
        r.finish = fin;
        r.window_now = cwnd;
        r.threshold_now = ssthresh;
        r.timeout_now_ms = t[15:0];
        r.last = (k == n - 1);
        expected_sends.push_back(r);
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_send_result(result_t got);
      result_t want;
      if (expected_sends.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
        return;
      end
      want = expected_sends.pop_front();
      check_field("send_valid", 16'(want.send_valid), 16'(got.send_valid));
      check_field("send_index", want.send_index, got.send_index);
      check_field("is_resend", 16'(want.is_resend), 16'(got.is_resend));
      check_field("finish", 16'(want.finish), 16'(got.finish));
      check_field("window_now", 16'(want.window_now), 16'(got.window_now));
      check_field("threshold_now", 16'(want.threshold_now), 16'(got.threshold_now));
      check_field("timeout_now_ms", want.timeout_now_ms, got.timeout_now_ms);
      check_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation_i = '0;
  logic [IDX_W-1:0]  ack_packets_i = '0;
  logic [MS_W-1:0]   rtt_sample_ms_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              send_valid_o;
  logic [IDX_W-1:0]  send_index_o;
  logic              is_resend_o;
  logic              finish_o;
  logic [WIN_W-1:0]  window_now_o;
  logic [WIN_W-1:0]  threshold_now_o;
  logic [MS_W-1:0]   timeout_now_ms_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [MS_W-1:0]   cfg_data_i = '0;

  congestion_scoreboard sb = new();
  int   tx_pct = 0;
  int   rx_pct = 0;
  logic hold_req = 1'b0;
  logic hold_armed = 1'b0;
  int   hold_left = 0;
  int   dup_burst = 0;

  tcp_reno_congestion_window uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      sb.check_send_result({send_valid_o, send_index_o, is_resend_o, finish_o,
                            window_now_o, threshold_now_o, timeout_now_ms_o, last_o});
    end
    if (!hold_req) begin
      hold_armed = 1'b0;
    end else if (!hold_armed) begin
      hold_armed = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(0, 99) < rx_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench NOT OK");
    $finish;
  end

  task automatic load_register(logic [1:0] index, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.note_register(index, data);
  endtask

  task automatic offer_event(logic [1:0] op, logic [15:0] ack, logic [15:0] sample);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    ack_packets_i <= ack;
    rtt_sample_ms_i <= sample;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.accept_event(op, ack, sample);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_sends.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly in-order cumulative acks over the outstanding window, with losses,
  // duplicate bursts, stale acks and arbitrary events mixed in.
  task automatic random_event(int loss);
    logic [1:0]  op;
    logic [15:0] ack;
    logic [15:0] sample;
    logic [15:0] span;
    int          pick;
    op = OP_ACK;
    ack = sb.highest_ack;
    sample = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(20, 3000));
    pick = $urandom_range(0, 99);
    if (sb.done) begin
      op = OP_START;
    end else if (dup_burst > 0) begin
      dup_burst--;
    end else if (pick < loss) begin
      case ($urandom_range(0, 7))
        0: op = OP_START;
        1, 2: begin
          op = 2'($urandom);
          ack = 16'($urandom);
        end
        3, 4: op = OP_TIMEOUT;
        default: dup_burst = $urandom_range(2, 3);
      endcase
    end else if (pick < loss + 4) begin
      if (sb.highest_ack > 16'd5) ack = sb.highest_ack - 16'($urandom_range(1, 5));
    end else if (sb.next_unsent > sb.highest_ack) begin
      span = sb.next_unsent - sb.highest_ack;
      ack = sb.highest_ack + 16'($urandom_range(1, span));
    end else begin
      ack = sb.end_reached ? sb.total_reg : sb.highest_ack + 16'd1;
    end
    offer_event(op, ack, sample);
  endtask

  task automatic run_phase(logic [15:0] total, logic [15:0] ssth, logic [15:0] tmo,
                           int sender_idle, int receiver_idle, int loss, int count,
                           logic pressure);
    load_register(CFG_TOTAL, total);
    load_register(CFG_SSTHRESH, ssth);
    load_register(CFG_TIMEOUT, tmo);
    cfg_valid_i <= 1'b0;
    tx_pct = sender_idle;
    rx_pct <= receiver_idle;
    hold_req <= pressure;
    dup_burst = 0;
    offer_event(OP_START, '0, '0);
    repeat (count - 1) random_event(loss);
    hold_req <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register reset values: a one-packet transfer.
    offer_event(OP_UNUSED, 16'hffff, 16'hffff);
    offer_event(OP_ACK, 16'd0, 16'd0);
    offer_event(OP_TIMEOUT, 16'd0, 16'd0);
    offer_event(OP_START, 16'd0, 16'd0);
    offer_event(OP_ACK, 16'd1, 16'd100);
    offer_event(OP_ACK, 16'd1, 16'd100);
    offer_event(OP_ACK, 16'd1, 16'd100);
    offer_event(OP_TIMEOUT, 16'd0, 16'd0);
    drain();

    load_register(CFG_TOTAL, 16'd40);
    load_register(CFG_SSTHRESH, 16'd2);
    load_register(CFG_TIMEOUT, 16'd1);
    cfg_valid_i <= 1'b0;
    offer_event(OP_START, 16'd0, 16'd0);
    offer_event(OP_ACK, 16'd1, 16'hffff);
    offer_event(OP_ACK, 16'd3, 16'd0);
    repeat (4) offer_event(OP_ACK, 16'd3, 16'd50);
    offer_event(OP_ACK, 16'd2, 16'd50);
    offer_event(OP_TIMEOUT, 16'd0, 16'd0);
    offer_event(OP_ACK, 16'hffff, 16'd70);
    offer_event(OP_TIMEOUT, 16'd0, 16'd0);
    offer_event(OP_ACK, 16'd40, 16'd70);
    offer_event(OP_ACK, 16'd0, 16'd70);
    drain();

    run_phase(16'd65535, 16'd64, 16'd65535, 0, 0, 0, 80, 1'b0);
    run_phase(16'd300, 16'd8, 16'd200, 46, 0, 12, 80, 1'b0);
    run_phase(16'd50, 16'd127, 16'd1, 0, 46, 12, 80, 1'b0);
    run_phase(16'd1000, 16'd2, 16'd500, 38, 38, 12, 80, 1'b0);
    run_phase(16'd2000, 16'd1, 16'd1200, 0, 0, 6, 70, 1'b1);

    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
